FILE: rtl/assert_macros.svh
// Assertion macros shared by the rescaler RTL.
// Depends on nothing; the synthesis build sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: rtl/dcr_pkg.sv
// Package for the drawing coordinate rescaler: constants, character codes, helpers.
// Depends on nothing.
package dcr_pkg;
  localparam int COORD_BITS_DEF      = 20;
  localparam int SCALE_FRAC_BITS_DEF = 16;
  localparam int SUM_W  = 33;
  localparam int PROD_W = 65;
  localparam int MAG_W  = 32;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_SCALE_X  = 2'd2;
  localparam logic [1:0] REG_SCALE_Y  = 2'd3;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_cmd(input logic [7:0] c);
    return c == 8'h6d || c == 8'h6e || c == 8'h6c || c == 8'h62 ||
           c == 8'h73 || c == 8'h70 || c == 8'h63;
  endfunction
endpackage

FILE: rtl/dcr_mult.sv
// Shift-and-add signed multiplier, one multiplier bit per cycle.
// Depends on dcr_pkg.
module dcr_mult (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [dcr_pkg::SUM_W-1:0] a,
  input  logic signed [31:0]          b,
  output logic                        done,
  output logic signed [dcr_pkg::PROD_W-1:0] prod
);
  import dcr_pkg::*;
  logic [5:0] cnt;
  logic       busy;
  logic signed [PROD_W-1:0] mcand;
  logic [31:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        prod   <= '0;
        mcand  <= PROD_W'(a);
        mplier <= b;
      end else if (busy) begin
        // Bit 31 carries negative weight in two's complement.
        if (mplier[0]) begin
          if (cnt == 6'd31) prod <= prod - mcand;
          else prod <= prod + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/drawing_coordinate_rescaler_unit.sv
// Top level of the drawing coordinate rescaler: tokeniser, sequencer, output register.
// Depends on dcr_pkg, dcr_mult and assert_macros.svh.
//
//  channel | direction | handshake        | payload
//  input   | in        | valid / stall    | in_char, end_of_string
//  output  | out       | out_valid / out_stall | out_char, last, empty_res
//  config  | in        | APB              | offset_x/y, scale_x/y
//
// A byte that ends no token is taken in the idle state; a token end adds a finish step and
// a string end an end-of-string step. A coordinate goes from its transfer through the serial
// multiplier and a rounding step, then one conversion step per decimal digit (up to 10), the
// space and sign steps and one step per digit sent. An output stall holds the output steps.
// Reset is synchronous and returns the token state and the offset and scale registers.
`include "assert_macros.svh"
module drawing_coordinate_rescaler_unit #(
  parameter int COORD_BITS      = dcr_pkg::COORD_BITS_DEF,
  parameter int SCALE_FRAC_BITS = dcr_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  in_char,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last,
  output logic        empty_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dcr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_START, S_MUL_WAIT, S_ROUND, S_CONV, S_SPACE, S_SIGN,
    S_DIGITS, S_CMD_SPACE, S_CMD, S_FINISH, S_EOS
  } state_t;

  state_t state;
  logic signed [20:0] offset_x, offset_y;
  logic signed [31:0] scale_x, scale_y;
  logic [COORD_BITS-1:0] token_value;
  logic [1:0]  token_length;
  logic        token_all_digits;
  logic [7:0]  token_first_char;
  logic        next_is_x, anything_emitted, eos, emitted_now;
  logic [MAG_W-1:0] mag;
  logic        neg;
  logic [3:0]  digits [11];
  logic [3:0]  ndig;
  logic signed [SUM_W-1:0] mul_a;
  logic        mul_start, mul_done;
  logic signed [PROD_W-1:0] mul_prod;
  logic        wr;
  logic [1:0]  widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[3:2];

  always_comb begin
    case (widx)
      REG_OFFSET_X: prdata = 32'(offset_x);
      REG_OFFSET_Y: prdata = 32'(offset_y);
      REG_SCALE_X:  prdata = scale_x;
      REG_SCALE_Y:  prdata = scale_y;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      scale_x  <= 32'sd65536;
      scale_y  <= 32'sd65536;
    end else if (wr) begin
      case (widx)
        REG_OFFSET_X: offset_x <= pwdata[20:0];
        REG_OFFSET_Y: offset_y <= pwdata[20:0];
        REG_SCALE_X:  scale_x  <= pwdata;
        REG_SCALE_Y:  scale_y  <= pwdata;
        default: ;
      endcase
    end
  end

  assign stall = (state != S_IDLE) || out_valid;
  wire accept = valid && !stall;
  wire out_go = out_valid && !out_stall;
  wire is_digit = in_char >= CH_ZERO && in_char <= CH_NINE;
  wire ends = (in_char == CH_SPACE) || end_of_string;

  // Value update for digits, with saturation.
  logic [COORD_BITS+3:0] tv_next;
  always_comb begin
    tv_next = {token_value, 3'b000} + {2'b00, token_value, 1'b0}
            + (COORD_BITS+4)'(in_char[3:0]);
    if (tv_next > (COORD_BITS+4)'({COORD_BITS{1'b1}}))
      tv_next = (COORD_BITS+4)'({COORD_BITS{1'b1}});
  end

  dcr_mult u_mult (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a),
    .b(next_is_x ? scale_x : scale_y), .done(mul_done), .prod(mul_prod)
  );

  // Rounding of the product; saturation follows in the round step.
  logic signed [PROD_W-1:0] t_val, r_val;
  logic [PROD_W-1:0] t_abs;
  always_comb begin
    t_val = mul_prod + (PROD_W'(1) <<< (SCALE_FRAC_BITS - 1));
    t_abs = t_val[PROD_W-1] ? PROD_W'(-t_val) : PROD_W'(t_val);
    t_abs = t_abs >> SCALE_FRAC_BITS;
    r_val = t_val[PROD_W-1] ? -$signed(t_abs) : $signed(t_abs);
  end

  // Division by ten through the reciprocal 2^35/10, exact for every 32-bit magnitude.
  wire [63:0] mag_recip = mag * 32'hCCCCCCCD;
  wire [MAG_W-1:0] mag_q = MAG_W'(mag_recip[63:35]);
  wire [3:0] mag_r = 4'(mag - MAG_W'(mag_q * 10));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      token_value <= '0;
      token_length <= '0;
      token_all_digits <= 1'b1;
      token_first_char <= '0;
      next_is_x <= 1'b1;
      anything_emitted <= 1'b0;
      eos <= 1'b0;
      emitted_now <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      if (out_go) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            emitted_now <= 1'b0;
            eos <= end_of_string;
            if (in_char != CH_SPACE) begin
              if (token_length == 2'd0) token_first_char <= in_char;
              if (token_length != 2'd2) token_length <= token_length + 2'd1;
              if (is_digit) token_value <= tv_next[COORD_BITS-1:0];
              else token_all_digits <= 1'b0;
            end
            if (ends) state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (token_length == 2'd0) state <= eos ? S_EOS : S_IDLE;
          else if (token_all_digits) begin
            mul_a <= SUM_W'(token_value) + SUM_W'(next_is_x ? offset_x : offset_y);
            mul_start <= 1'b1;
            state <= S_MUL_WAIT;
          end else if (token_length == 2'd1 && is_cmd(to_lower(token_first_char)))
            state <= S_CMD_SPACE;
          else state <= eos ? S_EOS : S_IDLE;
          if (!(token_length != 2'd0 && token_all_digits)) begin
            token_value <= '0;
            token_length <= '0;
            token_all_digits <= 1'b1;
            token_first_char <= token_length == 2'd1 ? token_first_char : '0;
          end
        end
        S_MUL_WAIT: if (mul_done) state <= S_ROUND;
        S_ROUND: begin
          if (r_val > PROD_W'(64'sh7fffffff)) begin
            neg <= 1'b0; mag <= 32'h7fffffff;
          end else if (r_val < -PROD_W'(64'sh80000000)) begin
            neg <= 1'b1; mag <= 32'h80000000;
          end else begin
            neg <= r_val[PROD_W-1];
            mag <= r_val[PROD_W-1] ? MAG_W'(-r_val) : MAG_W'(r_val);
          end
          ndig <= '0;
          token_value <= '0;
          token_length <= '0;
          token_all_digits <= 1'b1;
          token_first_char <= '0;
          state <= S_CONV;
        end
        S_CONV: begin
          digits[ndig] <= mag_r;
          ndig <= ndig + 4'd1;
          mag <= mag_q;
          if (mag_q == '0) state <= S_SPACE;
        end
        S_SPACE: if (!out_valid || out_go) begin
          if (anything_emitted) begin
            out_valid <= 1'b1; out_char <= CH_SPACE; last <= 1'b0; empty_res <= 1'b0;
          end
          anything_emitted <= 1'b1;
          state <= S_SIGN;
        end
        S_SIGN: if (!out_valid || out_go) begin
          if (neg) begin
            out_valid <= 1'b1; out_char <= CH_MINUS; last <= 1'b0; empty_res <= 1'b0;
          end
          state <= S_DIGITS;
        end
        S_DIGITS: if (!out_valid || out_go) begin
          out_valid <= 1'b1;
          out_char <= CH_ZERO + 8'(digits[ndig - 4'd1]);
          empty_res <= 1'b0;
          last <= eos && ndig == 4'd1;
          emitted_now <= 1'b1;
          ndig <= ndig - 4'd1;
          if (ndig == 4'd1) begin
            next_is_x <= !next_is_x;
            state <= eos ? S_EOS : S_IDLE;
          end
        end
        S_CMD_SPACE: if (!out_valid || out_go) begin
          if (anything_emitted) begin
            out_valid <= 1'b1; out_char <= CH_SPACE; last <= 1'b0; empty_res <= 1'b0;
          end
          anything_emitted <= 1'b1;
          state <= S_CMD;
        end
        S_CMD: if (!out_valid || out_go) begin
          out_valid <= 1'b1;
          out_char <= to_lower(token_first_char);
          last <= eos;
          empty_res <= 1'b0;
          emitted_now <= 1'b1;
          next_is_x <= 1'b1;
          token_first_char <= '0;
          state <= eos ? S_EOS : S_IDLE;
        end
        S_EOS: if (!out_valid || out_go) begin
          if (!emitted_now) begin
            out_valid <= 1'b1; out_char <= CH_NUL; last <= 1'b1;
            empty_res <= !anything_emitted;
          end
          next_is_x <= 1'b1;
          anything_emitted <= 1'b0;
          eos <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, state != S_IDLE, stall)
  `ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid && $stable(out_char))
  `ASSERT_IMPLIES(a_empty_last, clk, rst, out_valid && empty_res, last)
endmodule
